### rtl/fwh_pkg.sv
// Shared types for the fixed-width histogram core.
// Used by fwh_front, fwh_queue, fwh_back and the top level.
package fwh_pkg;

  localparam int unsigned CountOutBits = 32;
  localparam int unsigned BinBits      = 8;
  localparam int unsigned IdxBits      = 16;
  localparam int unsigned DivBits      = 32;
  localparam int unsigned DivStepBits  = 5;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_READ   = 1'b1
  } kind_t;

  // One classified request handed from the front to the back. The bin is
  // wide enough for the largest bin count the core is built for.
  typedef struct packed {
    kind_t               kind;
    logic [IdxBits-1:0]  bin;
    logic                drop;
    logic                addr_ok;
  } fwh_req_t;

endpackage

### rtl/fixed_width_histogram_core.sv
// Top level of the fixed-width histogram core.
// Depends on fwh_pkg, fwh_front, fwh_queue and fwh_back.
//
// Usage: requests enter through a queue-like port (push/full). kind 0 counts
// sample_value into the bin given by sample_value / bucket_width (truncated
// toward zero); kind 1 reads back the count of read_bin. Every request gives
// exactly one result on a second queue-like port (empty/pop) carrying the bin,
// the dropped flag, the bin count and the running sample total.
// A sample request keeps the front busy through the accept cycle, the 32
// steps of the one-bit-per-cycle restoring divider and the hand-off to the
// queue, which waits while the queue is full; a read request skips the
// divider. The back does the count memory read-modify-write per request and
// takes a request only when its result register is empty, and the front
// takes no new request until it has handed the last one to the queue.
// After reset the back sweeps the count memory to zero, one bin per cycle,
// and full stays high during that pass. Configuration writes
// (cfg_we, cfg_index, cfg_data) are taken at any time but are meant for idle.
// When the receiver stops popping, the result register holds its request, the
// back stops, the two-entry queue fills and the stalled front keeps full high.
module fixed_width_histogram_core import fwh_pkg::*; #(
  parameter int unsigned NUM_BINS   = 256,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               kind,
  input  logic signed [31:0] sample_value,
  input  logic [7:0]         read_bin,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         bin_index,
  output logic               dropped,
  output logic [31:0]        bin_count,
  output logic [31:0]        sample_total,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_data
);

  localparam logic CfgWidth = 1'b0;
  localparam logic CfgLimit = 1'b1;

  logic [30:0] bucket_width;
  logic [8:0]  bucket_limit;

  logic     front_busy;
  logic     clearing;
  logic     accept;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  fwh_req_t q_wdata;
  fwh_req_t q_rdata;
  logic     res_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_width <= 31'd1;
      bucket_limit <= 9'd256;
    end else if (cfg_we) begin
      if (cfg_index == CfgWidth) begin
        bucket_width <= cfg_data;
      end
      if (cfg_index == CfgLimit) begin
        bucket_limit <= cfg_data[8:0];
      end
    end
  end

  assign full   = front_busy || clearing;
  assign accept = push && !full;
  assign empty  = !res_valid;

  fwh_front #(
    .NUM_BINS(NUM_BINS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .kind(kind),
    .sample_value(sample_value),
    .read_bin(read_bin),
    .bucket_width(bucket_width),
    .bucket_limit(bucket_limit),
    .busy(front_busy),
    .q_push(q_push),
    .q_data(q_wdata),
    .q_full(q_full)
  );

  fwh_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .wdata(q_wdata),
    .full(q_full),
    .pop(q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  fwh_back #(
    .NUM_BINS(NUM_BINS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_data(q_rdata),
    .q_pop(q_pop),
    .clearing(clearing),
    .res_valid(res_valid),
    .res_take(pop),
    .res_bin(bin_index),
    .res_drop(dropped),
    .res_count(bin_count),
    .res_total(sample_total)
  );

endmodule

### rtl/fwh_front.sv
// Front part of the histogram core: accepts requests, divides samples.
// Depends on fwh_pkg; feeds fwh_queue.
module fwh_front import fwh_pkg::*; #(
  parameter int unsigned NUM_BINS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                kind,
  input  logic signed [31:0]  sample_value,
  input  logic [BinBits-1:0]  read_bin,
  input  logic [30:0]         bucket_width,
  input  logic [8:0]          bucket_limit,
  output logic                busy,
  output logic                q_push,
  output fwh_req_t            q_data,
  input  logic                q_full
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH
  } state_t;

  state_t                 state;
  kind_t                  kind_r;
  logic                   neg;
  logic [BinBits-1:0]     rbin;
  logic [DivBits-1:0]     quo;
  logic [DivBits-1:0]     rem;
  logic [DivStepBits-1:0] step;

  logic [30:0]        w_eff;
  logic [DivBits-1:0] rem_sh;
  logic               fits;
  logic [16:0]        lim;
  logic               s_drop;

  assign w_eff  = (bucket_width == 31'd0) ? 31'd1 : bucket_width;
  assign rem_sh = {rem[DivBits-2:0], quo[DivBits-1]};
  assign fits   = (rem_sh >= {1'b0, w_eff});
  assign lim    = (17'(bucket_limit) > 17'(NUM_BINS)) ? 17'(NUM_BINS) : 17'(bucket_limit);
  assign s_drop = (neg && (quo != '0)) || (quo >= 32'(lim));

  assign busy   = (state != ST_IDLE);
  assign q_push = (state == ST_PUSH) && !q_full;

  always_comb begin
    q_data.kind    = kind_r;
    q_data.bin     = '0;
    q_data.drop    = 1'b0;
    q_data.addr_ok = 1'b0;
    if (kind_r == KIND_READ) begin
      q_data.bin     = IdxBits'(rbin);
      q_data.addr_ok = ({9'd0, rbin} < 17'(NUM_BINS));
    end else begin
      q_data.drop    = s_drop;
      q_data.bin     = s_drop ? '0 : quo[IdxBits-1:0];
      q_data.addr_ok = !s_drop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            kind_r <= kind_t'(kind);
            rbin   <= read_bin;
            neg    <= sample_value[31];
            quo    <= sample_value[31] ? (~sample_value + 32'd1) : sample_value;
            rem    <= '0;
            step   <= '0;
            state  <= (kind_t'(kind) == KIND_READ) ? ST_PUSH : ST_DIV;
          end
        end
        ST_DIV: begin
          rem   <= fits ? (rem_sh - {1'b0, w_eff}) : rem_sh;
          quo   <= {quo[DivBits-2:0], fits};
          step  <= step + 1'b1;
          if (step == DivStepBits'(DivBits - 1)) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!q_full) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/fwh_queue.sv
// Two-entry request queue between the front and the back.
// Depends on fwh_pkg for the request type.
module fwh_queue import fwh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  fwh_req_t wdata,
  output logic     full,
  input  logic     pop,
  output fwh_req_t rdata,
  output logic     empty
);

  fwh_req_t   slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/fwh_back.sv
// Back part of the histogram core: count memory, update, result register.
// Depends on fwh_pkg; takes requests from fwh_queue.
module fwh_back import fwh_pkg::*; #(
  parameter int unsigned NUM_BINS   = 256,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_empty,
  input  fwh_req_t                q_data,
  output logic                    q_pop,
  output logic                    clearing,
  output logic                    res_valid,
  input  logic                    res_take,
  output logic [BinBits-1:0]      res_bin,
  output logic                    res_drop,
  output logic [CountOutBits-1:0] res_count,
  output logic [CountOutBits-1:0] res_total
);

  localparam int unsigned AddrBits = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  state_t                 state;
  logic [COUNT_BITS-1:0]  mem [NUM_BINS];
  logic [COUNT_BITS-1:0]  rd_data;
  logic [COUNT_BITS-1:0]  total;
  logic [AddrBits-1:0]    clr_idx;
  fwh_req_t               cur;

  logic [AddrBits-1:0]    rd_addr;
  logic [AddrBits-1:0]    cur_addr;
  logic [COUNT_BITS-1:0]  inc_count;
  logic [COUNT_BITS-1:0]  inc_total;
  logic                   do_add;

  assign clearing  = (state == ST_CLEAR);
  assign q_pop     = (state == ST_IDLE) && !q_empty && !res_valid;
  assign rd_addr   = AddrBits'(q_data.bin);
  assign cur_addr  = AddrBits'(cur.bin);
  assign inc_count = (rd_data == '1) ? rd_data : rd_data + 1'b1;
  assign inc_total = (total == '1) ? total : total + 1'b1;
  assign do_add    = (cur.kind == KIND_SAMPLE) && !cur.drop;

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (state == ST_CLEAR) begin
      mem[clr_idx] <= '0;
    end else if ((state == ST_UPDATE) && do_add) begin
      mem[cur_addr] <= inc_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      total     <= '0;
      res_valid <= 1'b0;
    end else begin
      // The result register is always empty while an update is in progress.
      if (res_take && (state != ST_UPDATE)) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AddrBits'(NUM_BINS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            cur   <= q_data;
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          res_valid <= 1'b1;
          res_bin   <= cur.bin[BinBits-1:0];
          res_drop  <= cur.drop;
          if (do_add) begin
            total     <= inc_total;
            res_count <= CountOutBits'(inc_count);
            res_total <= CountOutBits'(inc_total);
          end else begin
            res_count <= (cur.addr_ok && (cur.kind == KIND_READ)) ?
                         CountOutBits'(rd_data) : '0;
            res_total <= CountOutBits'(total);
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
